// File: hw/rtl/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// types, character codes, crc and alphabet helpers for the checksum unit
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

  localparam int CSC_BYTE_W      = 8;
  localparam int CSC_CRC_W       = 32;
  localparam int CSC_LEN_W       = 10;
  localparam int CSC_SUM_W       = CSC_LEN_W + CSC_CRC_W;
  localparam int CSC_DIGIT_W     = 6;
  localparam int CSC_IDX_W       = 3;
  localparam int CSC_QUEUE_DEPTH = 2;

  localparam logic [CSC_CRC_W-1:0]  CSC_CRC_POLY  = 32'hEDB8_8320;
  localparam logic [CSC_CRC_W-1:0]  CSC_CRC_ONES  = 32'hFFFF_FFFF;
  localparam logic [CSC_IDX_W-1:0]  CSC_LAST_IDX  = 3'd6;

  localparam logic [CSC_BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CSC_BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CSC_BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CSC_BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CSC_BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CSC_BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CSC_BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CSC_BYTE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CSC_BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CSC_BYTE_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CSC_BYTE_W-1:0] CH_MINUS   = 8'h2D;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_BLOCK  = 2'd1,
    MODE_LINE   = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic [CSC_BYTE_W-1:0] data_byte;
    logic                  byte_valid;
    logic                  end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [CSC_BYTE_W-1:0] char_code;
    logic [CSC_IDX_W-1:0]  char_index;
    logic                  last_char;
  } out_item_t;

  // finished checksum handed from front to back
  typedef struct packed {
    logic [CSC_LEN_W-1:0] len;
    logic [CSC_CRC_W-1:0] crc;
  } sum_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [CSC_CRC_W-1:0] crc_byte(input logic [CSC_CRC_W-1:0] crc,
                                                     input logic [CSC_BYTE_W-1:0] b);
    logic [CSC_CRC_W-1:0] x;
    x = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CSC_CRC_POLY) : (x >> 1);
    end
    return x ^ (crc >> 8);
  endfunction

  function automatic logic [CSC_BYTE_W-1:0] alpha_char(input logic [CSC_DIGIT_W-1:0] v);
    logic [CSC_BYTE_W-1:0] v8;
    logic [CSC_BYTE_W-1:0] r;
    v8 = {2'b00, v};
    if (v8 < 8'd26) begin
      r = CH_UPPER_A + v8;
    end else if (v8 < 8'd52) begin
      r = CH_LOWER_A + (v8 - 8'd26);
    end else if (v8 < 8'd62) begin
      r = CH_ZERO + (v8 - 8'd52);
    end else if (v8 == 8'd62) begin
      r = CH_PLUS;
    end else begin
      r = CH_MINUS;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/comment_stripping_crc32_checksum_unit.sv
// ----------------------------------------------------------------------------
// comment_stripping_crc32_checksum_unit
// strips c/c++ comments, folds whitespace, crc-32 plus length, base64-style out
// ----------------------------------------------------------------------------
//
//  channel  ports                         beat
//  -------  ----------------------------  ---------------------------------
//  input    in_push, in_full, in_item     one source byte and/or end flag
//  output   out_empty, out_pop, out_item  one checksum character
//
//  - one input beat per cycle while in_full is low; scan, crc update
//    and length update finish in the cycle of acceptance
//  - an end-of-file beat queues its checksum; the first character passes
//    through value_r and od_r, then one character per cycle while popped
//  - in_full follows the checksum queue only, so bytes stall only when
//    several checksums are waiting behind a stalled output
//  - synchronous active-low reset returns the scanner to normal mode and
//    empties queue and output register at the clock edge ending a reset cycle
// ----------------------------------------------------------------------------
`default_nettype none

module comment_stripping_crc32_checksum_unit
  import csc_pkg::*;
#(
  parameter int QUEUE_DEPTH = CSC_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  // input queue side
  input  wire logic      in_push,
  output logic           in_full,
  input  wire in_item_t  in_item,
  // result queue side
  output logic           out_empty,
  input  wire logic      out_pop,
  output out_item_t      out_item
);

  // front to back handoff
  queue_status_t q_status;
  logic          q_wr;
  logic          q_rd;
  sum_t          q_wr_data;
  sum_t          q_rd_data;

  // front: classifies each byte and folds it into crc and length
  csc_scanner u_scanner (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .q_status  (q_status),
    .q_wr      (q_wr),
    .q_wr_data (q_wr_data)
  );

  // short queue of finished checksums so both sides stall on their own
  csc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  // back: seven characters per checksum through a registered output
  csc_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_rd_data (q_rd_data),
    .q_rd      (q_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: hw/rtl/csc_scanner.sv
// ----------------------------------------------------------------------------
// csc_scanner
// front end: comment scanner, space folding, crc-32 and length per byte
// ----------------------------------------------------------------------------
`default_nettype none

module csc_scanner
  import csc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire in_item_t      in_item,
  input  wire queue_status_t q_status,
  output logic               q_wr,
  output sum_t               q_wr_data
);

  scan_mode_t            mode_r, mode_nxt;
  logic [CSC_BYTE_W-1:0] prior_r, prior_nxt;
  logic [CSC_BYTE_W-1:0] cbs_r, cbs_nxt;
  logic [CSC_CRC_W-1:0]  crc_r, crc_nxt;
  logic [CSC_CRC_W-1:0]  rb_r, rb_nxt;
  logic [CSC_LEN_W-1:0]  len_r, len_nxt;
  logic                  accept;

  assign in_full = q_status.full;
  assign accept  = in_push && !q_status.full;
  assign q_wr    = accept && in_item.end_of_file;

  always_comb begin
    logic [CSC_BYTE_W-1:0] c;
    c         = in_item.data_byte;
    mode_nxt  = mode_r;
    prior_nxt = prior_r;
    cbs_nxt   = cbs_r;
    crc_nxt   = crc_r;
    rb_nxt    = rb_r;
    len_nxt   = len_r;
    if (in_item.byte_valid) begin
      // comment close: closing byte becomes a space
      if (mode_nxt == MODE_BLOCK) begin
        if (prior_nxt == CH_STAR && c == CH_SLASH) begin
          mode_nxt  = MODE_NORMAL;
          prior_nxt = cbs_nxt;
          c         = CH_SPACE;
        end
      end else if (mode_nxt == MODE_LINE) begin
        if (c == CH_CR || c == CH_LF) begin
          mode_nxt  = MODE_NORMAL;
          prior_nxt = cbs_nxt;
          c         = CH_SPACE;
        end
      end
      if (mode_nxt != MODE_BLOCK && mode_nxt != MODE_LINE) begin
        if (c == CH_SLASH && prior_nxt != CH_SLASH) begin
          cbs_nxt = prior_nxt;
        end
        if (prior_nxt == CH_SLASH && c == CH_STAR) begin
          // block opener: undo the counted slash
          mode_nxt = MODE_BLOCK;
          crc_nxt  = rb_nxt;
          len_nxt  = len_nxt - 1'b1;
          c        = CH_SPACE;
        end else if (prior_nxt == CH_SLASH && c == CH_SLASH) begin
          mode_nxt = MODE_LINE;
          crc_nxt  = rb_nxt;
          len_nxt  = len_nxt - 1'b1;
        end else begin
          if (c == CH_TAB || c == CH_CR || c == CH_LF) begin
            c = CH_SPACE;
          end
          if (c != CH_SPACE || prior_nxt != CH_SPACE) begin
            rb_nxt  = crc_nxt;
            crc_nxt = crc_byte(crc_nxt, c);
            len_nxt = len_nxt + 1'b1;
          end
        end
      end
      prior_nxt = c;
    end
    q_wr_data.len = len_nxt;
    q_wr_data.crc = crc_nxt ^ CSC_CRC_ONES;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || q_wr) begin
      mode_r  <= MODE_NORMAL;
      prior_r <= CH_SPACE;
      cbs_r   <= CH_SPACE;
      crc_r   <= CSC_CRC_ONES;
      rb_r    <= CSC_CRC_ONES;
      len_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      prior_r <= prior_nxt;
      cbs_r   <= cbs_nxt;
      crc_r   <= crc_nxt;
      rb_r    <= rb_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/csc_queue.sv
// ----------------------------------------------------------------------------
// csc_queue
// short fifo of finished checksums between scanner and serializer
// ----------------------------------------------------------------------------
`default_nettype none

module csc_queue
  import csc_pkg::*;
#(
  parameter int DEPTH = CSC_QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    wr,
  input  wire sum_t    wr_data,
  input  wire logic    rd,
  output sum_t         rd_data,
  output queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

  sum_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign status.full  = (cnt_r == DEPTH_C);
  assign status.empty = (cnt_r == '0);
  assign do_wr   = wr && !status.full;
  assign do_rd   = rd && !status.empty;
  assign rd_data = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == LAST_P) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == LAST_P) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/csc_serializer.sv
// ----------------------------------------------------------------------------
// csc_serializer
// back end: turns one checksum into seven base64-style characters
// ----------------------------------------------------------------------------
`default_nettype none

module csc_serializer
  import csc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire queue_status_t q_status,
  input  wire sum_t          q_rd_data,
  output logic               q_rd,
  output logic               out_empty,
  input  wire logic          out_pop,
  output out_item_t          out_item
);

  logic [CSC_SUM_W-1:0] value_r, value_nxt;
  logic [CSC_IDX_W-1:0] idx_r, idx_nxt;
  logic                 busy_r, busy_nxt;
  logic                 ov_r, ov_nxt;
  out_item_t            od_r, od_nxt;
  logic                 advance;

  assign advance   = busy_r && (!ov_r || out_pop);
  assign q_rd      = !q_status.empty && (!busy_r || (advance && idx_r == CSC_LAST_IDX));
  assign out_empty = !ov_r;
  assign out_item  = od_r;

  always_comb begin
    value_nxt = value_r;
    idx_nxt   = idx_r;
    busy_nxt  = busy_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    if (advance) begin
      ov_nxt            = 1'b1;
      od_nxt.char_code  = alpha_char(value_r[CSC_SUM_W-1 -: CSC_DIGIT_W]);
      od_nxt.char_index = idx_r;
      od_nxt.last_char  = (idx_r == CSC_LAST_IDX);
      value_nxt         = value_r << CSC_DIGIT_W;
      idx_nxt           = idx_r + 1'b1;
      if (idx_r == CSC_LAST_IDX) begin
        busy_nxt = 1'b0;
      end
    end else if (out_pop) begin
      ov_nxt = 1'b0;
    end
    if (q_rd) begin
      value_nxt = q_rd_data;
      idx_nxt   = '0;
      busy_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    od_r    <= od_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/csc_checker.sv
// ----------------------------------------------------------------------------
// csc_checker
// port-level checks on the character stream of the checksum unit
// ----------------------------------------------------------------------------
`default_nettype none

module csc_checker
  import csc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_full,
  input wire logic      out_empty,
  input wire logic      out_pop,
  input wire out_item_t out_item
);

  // output register is cleared by reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("output not empty after reset");

  // checksum queue is empty after reset, so input is open
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // last flag marks exactly the final position
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.last_char == (out_item.char_index == CSC_LAST_IDX)))
    else $error("last_char does not match char_index");

  // characters of one checksum come without a gap in index order
  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_item.last_char) |=>
      (!out_empty && out_item.char_index == $past(out_item.char_index) + 3'd1))
    else $error("checksum character sequence broken");

  // a stalled character holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("stalled output changed");

endmodule

bind comment_stripping_crc32_checksum_unit csc_checker u_csc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);

`default_nettype wire
